// ----- rtl/bpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bpq_pkg
// shared types and codes of the bucket priority queue: request and status
// codes, controller states and the command and status groups that join the
// controller to the datapath
// ----------------------------------------------------------------------------
package bpq_pkg;

    typedef enum logic
    {
        ACT_INSERT = 1'b0,
        ACT_GET    = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        S_CLEAR,
        S_IDLE,
        S_MOD1,
        S_MOD2,
        S_INS_RD,
        S_INS_WR,
        S_EMPTY,
        S_SCAN,
        S_GET_RD,
        S_GET_OUT
    } state_t;

    // source of the bucket-state read address
    typedef enum logic [1:0]
    {
        MSRC_HOLD,
        MSRC_INS,
        MSRC_SCAN
    } meta_src_t;

    // kind of result loaded into the output register
    typedef enum logic [1:0]
    {
        RES_OK,
        RES_EMPTY,
        RES_FULL,
        RES_TASK
    } res_kind_t;

    typedef struct packed
    {
        logic      in_ready;
        logic      capture;
        logic      clear_wr;
        logic      latch_bucket;
        logic      scan_start;
        logic      scan_step;
        logic      get_found;
        logic      get_commit;
        logic      ins_commit;
        logic      res_load;
        meta_src_t meta_src;
        res_kind_t res_kind;
    } bpq_cmd_t;

    typedef struct packed
    {
        logic    in_valid;
        action_t in_action;
        logic    total_zero;
        logic    out_free;
        logic    found;
        logic    full;
        logic    clr_last;
    } bpq_stat_t;

endpackage

// ----- rtl/bpq_if.sv -----
// ----------------------------------------------------------------------------
// bpq_req_if / bpq_rsp_if
// valid/ready channels of the bucket priority queue: requests in, results out
// ----------------------------------------------------------------------------
interface bpq_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] task_id;
    logic [15:0] task_priority;
    logic [15:0] task_run_time;

    modport source
    (
        output valid,
        output action,
        output task_id,
        output task_priority,
        output task_run_time,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  task_id,
        input  task_priority,
        input  task_run_time,
        output ready
    );
endinterface

interface bpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_id;
    logic [15:0] out_priority;
    logic [15:0] out_run_time;
    logic [1:0]  status;

    modport source
    (
        output valid,
        output out_id,
        output out_priority,
        output out_run_time,
        output status,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  out_id,
        input  out_priority,
        input  out_run_time,
        input  status,
        output ready
    );
endinterface

// ----- rtl/bpq_ram.sv -----
// ----------------------------------------------------------------------------
// bpq_ram
// simple dual-port ram: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module bpq_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpq_ctrl
// sequencer of the bucket priority queue: clearing pass, insert and get
// command sequences, result hand-off
// ----------------------------------------------------------------------------
module bpq_ctrl
    import bpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bpq_stat_t stat,
    output bpq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.meta_src     = MSRC_HOLD;
        cmd.res_kind     = RES_OK;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (stat.in_action == ACT_INSERT)
                    begin
                        state_next = S_MOD1;
                    end
                    else if (stat.total_zero)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_MOD1:
            begin
                state_next = S_MOD2;
            end
            S_MOD2:
            begin
                state_next = S_INS_RD;
            end
            S_INS_RD:
            begin
                cmd.meta_src     = MSRC_INS;
                cmd.latch_bucket = 1'b1;
                state_next       = S_INS_WR;
            end
            S_INS_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    if (stat.full)
                    begin
                        cmd.res_kind = RES_FULL;
                    end
                    else
                    begin
                        cmd.ins_commit = 1'b1;
                        cmd.res_kind   = RES_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_EMPTY;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.meta_src  = MSRC_SCAN;
                cmd.scan_step = 1'b1;
                if (stat.found)
                begin
                    cmd.get_found = 1'b1;
                    state_next    = S_GET_RD;
                end
            end
            S_GET_RD:
            begin
                cmd.get_commit = 1'b1;
                state_next     = S_GET_OUT;
            end
            S_GET_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_TASK;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/bpq_datapath.sv -----
// ----------------------------------------------------------------------------
// bpq_datapath
// request capture, bucket selection by reciprocal multiply, bucket state and
// task memories, lowest-bucket scan, occupancy tracking and result register
// ----------------------------------------------------------------------------
module bpq_datapath
    import bpq_pkg::*;
#(
    parameter int NUM_BUCKETS  = 256,
    parameter int BUCKET_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  bpq_cmd_t  cmd,
    output bpq_stat_t stat,
    bpq_req_if.sink   request,
    bpq_rsp_if.source response
);

    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int SW     = $clog2(BUCKET_DEPTH);
    localparam int CW     = $clog2(BUCKET_DEPTH + 1);
    localparam int MW     = SW + CW;
    localparam int EAW    = BW + SW;
    localparam int EDEPTH = NUM_BUCKETS * (2 ** SW);
    localparam int TW     = $clog2(NUM_BUCKETS * BUCKET_DEPTH + 1);
    // ceil(2^32 / NUM_BUCKETS), exact quotient for any 16-bit priority
    localparam longint unsigned RECIP = ((64'd1 << 32) + NUM_BUCKETS - 1) / NUM_BUCKETS;
    localparam logic [31:0] RECIP_W = RECIP[31:0];
    localparam logic [15:0] NB_W    = 16'(NUM_BUCKETS);

    // captured request
    logic        act_reg;
    logic [15:0] id_reg;
    logic [15:0] prio_reg;
    logic [15:0] rt_reg;

    // bucket selection pipeline
    logic [47:0]   prod1_reg;
    logic [15:0]   prod2_reg;
    logic [15:0]   quot;
    logic [15:0]   rem;
    logic [BW-1:0] ins_bucket;

    // working bucket
    logic [BW-1:0] bucket_reg;
    logic [SW-1:0] head_reg;
    logic [CW-1:0] count_reg;

    // control state
    logic [TW-1:0] total_reg;
    logic [BW-1:0] min_ptr_reg;
    logic [BW-1:0] clr_ptr_reg;
    logic [BW-1:0] scan_ptr_reg;
    logic [BW-1:0] look_ptr_reg;
    logic          look_valid_reg;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_id_reg;
    logic [15:0] out_prio_reg;
    logic [15:0] out_rt_reg;
    status_t     out_status_reg;

    // memories
    logic          meta_we;
    logic [BW-1:0] meta_waddr;
    logic [MW-1:0] meta_wdata;
    logic [BW-1:0] meta_raddr;
    logic [MW-1:0] meta_rdata;
    logic [SW-1:0] meta_head;
    logic [CW-1:0] meta_count;

    logic [EAW-1:0] ent_waddr;
    logic [EAW-1:0] ent_raddr;
    logic [47:0]    ent_wdata;
    logic [47:0]    ent_rdata;

    logic [SW:0]   tail_sum;
    logic [SW:0]   tail_wrap;
    logic [SW-1:0] tail;
    logic [SW-1:0] head_inc;
    logic          out_free;

    assign quot       = prod1_reg[47:32];
    assign rem        = prio_reg - prod2_reg;
    assign ins_bucket = rem[BW-1:0];

    assign meta_head  = meta_rdata[MW-1:CW];
    assign meta_count = meta_rdata[CW-1:0];

    assign tail_sum  = {1'b0, meta_head} + (SW + 1)'(meta_count);
    assign tail_wrap = (tail_sum >= (SW + 1)'(BUCKET_DEPTH)) ?
                       tail_sum - (SW + 1)'(BUCKET_DEPTH) : tail_sum;
    assign tail      = tail_wrap[SW-1:0];
    assign head_inc  = (head_reg == SW'(BUCKET_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign out_free = !out_valid_reg || response.ready;

    always_comb
    begin
        unique case (cmd.meta_src)
            MSRC_INS:  meta_raddr = ins_bucket;
            MSRC_SCAN: meta_raddr = scan_ptr_reg;
            default:   meta_raddr = bucket_reg;
        endcase
    end

    always_comb
    begin
        meta_we    = cmd.clear_wr || cmd.ins_commit || cmd.get_commit;
        meta_waddr = bucket_reg;
        meta_wdata = {meta_head, meta_count + 1'b1};
        if (cmd.clear_wr)
        begin
            meta_waddr = clr_ptr_reg;
            meta_wdata = '0;
        end
        else if (cmd.get_commit)
        begin
            meta_wdata = {head_inc, count_reg - 1'b1};
        end
    end

    assign ent_waddr = {bucket_reg, tail};
    assign ent_raddr = {bucket_reg, head_reg};
    assign ent_wdata = {id_reg, prio_reg, rt_reg};

    bpq_ram
    #(
        .WIDTH (MW),
        .DEPTH (NUM_BUCKETS)
    )
    u_meta_ram
    (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    bpq_ram
    #(
        .WIDTH (48),
        .DEPTH (EDEPTH)
    )
    u_entry_ram
    (
        .clk   (clk),
        .we    (cmd.ins_commit),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= request.action;
            id_reg   <= request.task_id;
            prio_reg <= request.task_priority;
            rt_reg   <= request.task_run_time;
        end
        prod1_reg <= 48'(prio_reg) * 48'(RECIP_W);
        prod2_reg <= 16'(32'(quot) * 32'(NB_W));
        if (cmd.latch_bucket)
        begin
            bucket_reg <= ins_bucket;
        end
        else if (cmd.get_found)
        begin
            bucket_reg <= look_ptr_reg;
            head_reg   <= meta_head;
            count_reg  <= meta_count;
        end
        if (cmd.scan_start)
        begin
            scan_ptr_reg <= min_ptr_reg;
        end
        else if (cmd.scan_step)
        begin
            scan_ptr_reg <= scan_ptr_reg + 1'b1;
            look_ptr_reg <= scan_ptr_reg;
        end
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                RES_TASK:
                begin
                    out_id_reg     <= ent_rdata[47:32];
                    out_prio_reg   <= ent_rdata[31:16];
                    out_rt_reg     <= ent_rdata[15:0];
                    out_status_reg <= STATUS_OK;
                end
                RES_EMPTY:
                begin
                    out_id_reg     <= '0;
                    out_prio_reg   <= '0;
                    out_rt_reg     <= '0;
                    out_status_reg <= STATUS_EMPTY;
                end
                RES_FULL:
                begin
                    out_id_reg     <= '0;
                    out_prio_reg   <= '0;
                    out_rt_reg     <= '0;
                    out_status_reg <= STATUS_FULL;
                end
                default:
                begin
                    out_id_reg     <= '0;
                    out_prio_reg   <= '0;
                    out_rt_reg     <= '0;
                    out_status_reg <= STATUS_OK;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            min_ptr_reg    <= '0;
            clr_ptr_reg    <= '0;
            look_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end
            if (cmd.ins_commit)
            begin
                total_reg <= total_reg + 1'b1;
                if (bucket_reg < min_ptr_reg)
                begin
                    min_ptr_reg <= bucket_reg;
                end
            end
            else if (cmd.get_commit)
            begin
                total_reg   <= total_reg - 1'b1;
                min_ptr_reg <= bucket_reg;
            end
            if (cmd.scan_start)
            begin
                look_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                look_valid_reg <= 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign request.ready = cmd.in_ready;

    assign response.valid        = out_valid_reg;
    assign response.out_id       = out_id_reg;
    assign response.out_priority = out_prio_reg;
    assign response.out_run_time = out_rt_reg;
    assign response.status       = out_status_reg;

    assign stat.in_valid   = request.valid;
    assign stat.in_action  = action_t'(request.action);
    assign stat.total_zero = (total_reg == '0);
    assign stat.out_free   = out_free;
    assign stat.found      = look_valid_reg && (meta_count != '0) && (act_reg == ACT_GET);
    assign stat.full       = (meta_count == CW'(BUCKET_DEPTH));
    assign stat.clr_last   = (clr_ptr_reg == BW'(NUM_BUCKETS - 1));

endmodule

// ----- rtl/bucket_priority_queue.sv -----
// ----------------------------------------------------------------------------
// bucket_priority_queue
// task table of NUM_BUCKETS fifo buckets, each BUCKET_DEPTH tasks deep
// ----------------------------------------------------------------------------
// An insert puts a task into the bucket given by its priority modulo
// NUM_BUCKETS and returns status ok, or status full when that bucket holds
// BUCKET_DEPTH tasks; a get returns the oldest task of the lowest-numbered
// non-empty bucket, or status empty when the table holds nothing. Every
// request gives one result. After reset the block runs a clearing pass over
// the bucket state memory before it takes its first request. An insert
// passes two multiply stages that select the bucket, then one read and one
// write of the bucket state memory. An empty get skips the scan. A get
// scans the buckets, one per cycle through the bucket state memory port,
// from the lowest bucket that may hold a task up to the one served, then
// reads that task. A request is taken while the previous result still
// waits in the output register.
// ----------------------------------------------------------------------------
module bucket_priority_queue
    import bpq_pkg::*;
#(
    parameter int NUM_BUCKETS  = 256,
    parameter int BUCKET_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    bpq_req_if.sink   request,
    bpq_rsp_if.source response
);

    bpq_cmd_t  cmd;
    bpq_stat_t stat;

    bpq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    bpq_datapath
    #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .request  (request),
        .response (response)
    );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of bucket_priority_queue: a scoreboard keeps its own
// copy of the bucket table, predicts the result of every request and compares
// each response field by field; directed requests hit the table edges, then
// random phases alternate fill-heavy and drain-heavy traffic with random
// idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
    logic [15:0]       id;
    logic [15:0]       prio;
    logic [15:0]       run_time;
    bpq_pkg::status_t  status;
} task_result_t;

class task_table_scoreboard #(int BUCKETS = 256, int DEPTH = 16);
    logic [47:0]  slot_data [BUCKETS*DEPTH];
    int           head      [BUCKETS];
    int           fill      [BUCKETS];
    task_result_t pending_results [$];
    int           errors;
    int           stored;
    int           refused;
    int           served;
    int           empty_gets;

    function new();
        for (int b = 0; b < BUCKETS; b++)
        begin
            head[b] = 0;
            fill[b] = 0;
        end
        errors     = 0;
        stored     = 0;
        refused    = 0;
        served     = 0;
        empty_gets = 0;
    endfunction

    function int pending_count();
        return pending_results.size();
    endfunction

    function void note_request(bpq_pkg::action_t act, logic [15:0] id,
                               logic [15:0] prio, logic [15:0] run_time);
        task_result_t res;
        int           b;
        int           slot;
        logic [47:0]  e;

        res.id       = '0;
        res.prio     = '0;
        res.run_time = '0;
        res.status   = bpq_pkg::STATUS_OK;
        if (act == bpq_pkg::ACT_INSERT)
        begin
            b = int'(prio) % BUCKETS;
            if (fill[b] >= DEPTH)
            begin
                res.status = bpq_pkg::STATUS_FULL;
                refused++;
            end
            else
            begin
                slot = (head[b] + fill[b]) % DEPTH;
                slot_data[b*DEPTH + slot] = {id, prio, run_time};
                fill[b]++;
                stored++;
            end
        end
        else
        begin
            res.status = bpq_pkg::STATUS_EMPTY;
            for (b = 0; b < BUCKETS; b++)
            begin
                if (fill[b] != 0)
                begin
                    e            = slot_data[b*DEPTH + head[b]];
                    head[b]      = (head[b] + 1) % DEPTH;
                    fill[b]--;
                    res.id       = e[47:32];
                    res.prio     = e[31:16];
                    res.run_time = e[15:0];
                    res.status   = bpq_pkg::STATUS_OK;
                    break;
                end
            end
            if (res.status == bpq_pkg::STATUS_EMPTY)
                empty_gets++;
            else
                served++;
        end
        pending_results.push_back(res);
    endfunction

    function void check_result(task_result_t got);
        task_result_t want;

        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual id %h prio %h rt %h st %0d",
                     $time, got.id, got.prio, got.run_time, got.status);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got.id !== want.id)
        begin
            $display("%0t: out_id mismatch, expected %h, actual %h", $time, want.id, got.id);
            errors++;
        end
        if (got.prio !== want.prio)
        begin
            $display("%0t: out_priority mismatch, expected %h, actual %h",
                     $time, want.prio, got.prio);
            errors++;
        end
        if (got.run_time !== want.run_time)
        begin
            $display("%0t: out_run_time mismatch, expected %h, actual %h",
                     $time, want.run_time, got.run_time);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
        end
    endfunction
endclass

module testbench;
    import bpq_pkg::*;

    localparam int BUCKETS      = 256;
    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1330;
    localparam int PHASE_LEN    = 150;
    localparam int DRAIN_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;
    bit   sender_idle;
    bit   receiver_idle;

    task_table_scoreboard #(BUCKETS, DEPTH) sb;

    bpq_req_if request_bus ();
    bpq_rsp_if response_bus ();

    bucket_priority_queue #(
        .NUM_BUCKETS  (BUCKETS),
        .BUCKET_DEPTH (DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_bus.sink),
        .response (response_bus.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(action_t act, logic [15:0] id, logic [15:0] prio,
                                logic [15:0] run_time);
        int gap;

        gap = sender_idle ? $urandom_range(0, 10) : 0;
        if (gap != 0)
        begin
            request_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_bus.valid         <= 1'b1;
        request_bus.action        <= act;
        request_bus.task_id       <= id;
        request_bus.task_priority <= prio;
        request_bus.task_run_time <= run_time;
        do
            @(posedge clk);
        while (!request_bus.ready);
        sb.note_request(act, id, prio, run_time);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        request_bus.valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(negedge clk);
    endtask

    // response side
    initial
    begin
        task_result_t got;
        int           stall;
        int           taken;

        taken              = 0;
        receiver_idle      = 1'b1;
        response_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = receiver_idle ? $urandom_range(0, 10) : 0;
            if (stall != 0)
            begin
                response_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            response_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!response_bus.valid);
            got.id       = response_bus.out_id;
            got.prio     = response_bus.out_priority;
            got.run_time = response_bus.out_run_time;
            got.status   = status_t'(response_bus.status);
            sb.check_result(got);
            taken++;
            if (taken % 120 == 0)
                receiver_idle = ($urandom_range(0, 3) != 0);
        end
    end

    // request side
    initial
    begin
        logic [7:0]  hot_bucket [3];
        int          insert_pct;
        int          r;
        action_t     act;
        logic [15:0] prio;

        sb = new();
        sender_idle               = 1'b1;
        rst_n                     = 1'b0;
        request_bus.valid         = 1'b0;
        request_bus.action        = ACT_INSERT;
        request_bus.task_id       = '0;
        request_bus.task_priority = '0;
        request_bus.task_run_time = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, field extremes, bucket order, one full bucket
        send_request(ACT_GET, 16'hffff, 16'hffff, 16'hffff);
        send_request(ACT_INSERT, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_INSERT, 16'hffff, 16'hffff, 16'hffff);
        send_request(ACT_INSERT, 16'h0001, 16'h0100, 16'h1234);
        send_request(ACT_GET, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_GET, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_GET, 16'h0000, 16'h0000, 16'h0000);
        send_request(ACT_GET, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i <= DEPTH; i++)
            send_request(ACT_INSERT, 16'(16'ha500 + i), 16'(16'h0080 + i*256),
                         16'(16'h5a00 + i));

        // random phases
        insert_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    2:       insert_pct = 75;
                    default: insert_pct = 95;
                endcase
                for (int h = 0; h < 3; h++)
                    hot_bucket[h] = 8'($urandom);
                sender_idle = ($urandom_range(0, 3) != 0);
            end
            if (n == RANDOM_ITEMS / 2)
                wait_all_results();
            act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_GET;
            r   = $urandom_range(0, 99);
            if (r < 50)
                prio = {8'($urandom), hot_bucket[$urandom_range(0, 2)]};
            else if (r < 65)
                prio = {8'($urandom), 8'($urandom_range(0, 3))};
            else
                prio = 16'($urandom);
            send_request(act, 16'($urandom), prio, 16'($urandom));
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("requests: %0d tasks stored, %0d refused on full bucket",
                 sb.stored, sb.refused);
        $display("gets: %0d tasks served, %0d on empty table", sb.served, sb.empty_gets);
        if (sb.errors == 0 && sb.pending_count() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
